>>> design/rsx_pkg.sv
// Shared types, codes and constants for the RISC subset execute unit.
// No dependencies; every other design file imports this package.
package rsx_pkg;

  // Register file size default and fixed architectural constants
  localparam int          NUM_REGS_DEF = 32;
  localparam logic [4:0]  LINK_REG     = 5'd31;
  localparam logic [31:0] PC_STEP      = 32'd4;

  // Operation codes on the input channel
  localparam logic [3:0] ACT_ADD  = 4'd0;
  localparam logic [3:0] ACT_SUB  = 4'd1;
  localparam logic [3:0] ACT_AND  = 4'd2;
  localparam logic [3:0] ACT_JR   = 4'd3;
  localparam logic [3:0] ACT_ADDI = 4'd4;
  localparam logic [3:0] ACT_ORI  = 4'd5;
  localparam logic [3:0] ACT_ANDI = 4'd6;
  localparam logic [3:0] ACT_J    = 4'd7;
  localparam logic [3:0] ACT_JAL  = 4'd8;

  // ALU function select
  localparam logic [1:0] ALU_ADD = 2'd0;
  localparam logic [1:0] ALU_SUB = 2'd1;
  localparam logic [1:0] ALU_AND = 2'd2;
  localparam logic [1:0] ALU_OR  = 2'd3;

  // Next-PC source select
  localparam logic [1:0] PCS_HOLD   = 2'd0;
  localparam logic [1:0] PCS_STEP   = 2'd1;
  localparam logic [1:0] PCS_TARGET = 2'd2;
  localparam logic [1:0] PCS_RS     = 2'd3;

  typedef struct packed {
    logic [3:0]         action;
    logic [4:0]         src_reg_a;
    logic [4:0]         src_reg_b;
    logic [4:0]         dest_reg;
    logic signed [15:0] immediate;
    logic [31:0]        jump_target;
  } in_t;

  typedef struct packed {
    logic [31:0]        next_pc;
    logic               write_valid;
    logic [4:0]         write_index;
    logic signed [31:0] write_value;
  } out_t;

  // Classified instruction handed from front to back
  typedef struct packed {
    logic [1:0]  alu_op;
    logic [1:0]  pc_sel;
    logic        use_imm;
    logic        link;
    logic        wr_en;
    logic [4:0]  wr_idx;
    logic [4:0]  rs;
    logic        rs_ok;
    logic [4:0]  rt;
    logic        rt_ok;
    logic [31:0] imm;
    logic [31:0] target;
  } dec_t;

endpackage

>>> design/rsx_front.sv
// Front end: classifies each incoming instruction into a dec_t beat.
// Depends on rsx_pkg.
module rsx_front import rsx_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  in_t  in_data,
  output dec_t dec
);

  function automatic logic reg_ok(input logic [4:0] idx);
    reg_ok = (idx != '0) && (int'(idx) < NUM_REGS);
  endfunction

  // Decode operand sources, destination and PC source
  always_comb begin
    dec        = '0;
    dec.rs     = in_data.src_reg_a;
    dec.rs_ok  = reg_ok(in_data.src_reg_a);
    dec.rt     = in_data.src_reg_b;
    dec.rt_ok  = reg_ok(in_data.src_reg_b);
    dec.target = in_data.jump_target;
    dec.imm    = {{16{in_data.immediate[15]}}, in_data.immediate};
    dec.pc_sel = PCS_HOLD;
    dec.alu_op = ALU_ADD;
    case (in_data.action)
      ACT_ADD, ACT_SUB, ACT_AND: begin
        dec.alu_op = (in_data.action == ACT_ADD) ? ALU_ADD :
                     (in_data.action == ACT_SUB) ? ALU_SUB : ALU_AND;
        dec.pc_sel = PCS_STEP;
        dec.wr_en  = reg_ok(in_data.dest_reg);
        dec.wr_idx = in_data.dest_reg;
      end
      ACT_ADDI, ACT_ORI, ACT_ANDI: begin
        dec.alu_op  = (in_data.action == ACT_ADDI) ? ALU_ADD :
                      (in_data.action == ACT_ORI)  ? ALU_OR  : ALU_AND;
        dec.use_imm = 1'b1;
        if (in_data.action != ACT_ADDI) begin
          dec.imm = {16'b0, in_data.immediate};
        end
        dec.pc_sel = PCS_STEP;
        dec.wr_en  = reg_ok(in_data.src_reg_b);
        dec.wr_idx = in_data.src_reg_b;
      end
      ACT_JR: begin
        dec.pc_sel = PCS_RS;
      end
      ACT_J: begin
        dec.pc_sel = PCS_TARGET;
      end
      ACT_JAL: begin
        dec.pc_sel = PCS_TARGET;
        dec.link   = 1'b1;
        dec.wr_en  = reg_ok(LINK_REG);
        dec.wr_idx = LINK_REG;
      end
      default: begin
        dec.pc_sel = PCS_HOLD;
      end
    endcase
    // Drop the index on a write that does not land
    if (!dec.wr_en) begin
      dec.wr_idx = '0;
    end
  end

endmodule

>>> design/rsx_queue.sv
// Two-entry queue that decouples the front end from the back end.
// Depends on rsx_pkg for the dec_t beat type.
module rsx_queue import rsx_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  dec_t push_data,
  output logic pop_valid,
  input  logic pop_ready,
  output dec_t pop_data
);

  dec_t       ent_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push, pop;

  assign push_ready = (cnt_r != 2'd2);
  assign pop_valid  = (cnt_r != 2'd0);
  assign pop_data   = ent_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // Store the incoming beat
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= ~wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= ~rd_ptr_r;
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + 2'd1;
      end else if (pop && !push) begin
        cnt_r <= cnt_r - 2'd1;
      end
    end
  end

endmodule

>>> design/rsx_back.sv
// Back end: register file read, execute, write back, PC update and result register.
// Depends on rsx_pkg.
module rsx_back import rsx_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic dq_valid,
  output logic dq_ready,
  input  dec_t dq_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  localparam int IDX_W = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;

  logic [31:0]         rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0] vld_r;

  logic        ex_valid_r;
  dec_t        ex_r;
  logic [31:0] rda_r, rdb_r;
  logic        a_vld_r, b_vld_r;

  logic        lw_en_r;
  logic [4:0]  lw_idx_r;
  logic [31:0] lw_val_r;

  logic [31:0] pc_r;
  logic        out_valid_r;
  out_t        out_r;

  logic        ex_fire, pop;
  logic [31:0] opa, opb_reg, opb, alu, pc_step, wval, next_pc;

  assign ex_fire   = ex_valid_r && (!out_valid_r || out_ready);
  assign dq_ready  = !ex_valid_r || ex_fire;
  assign pop       = dq_valid && dq_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // Read stage: registered reads, capture the beat
  always_ff @(posedge clk) begin
    if (pop) begin
      ex_r    <= dq_data;
      rda_r   <= rf_mem[dq_data.rs[IDX_W-1:0]];
      rdb_r   <= rf_mem[dq_data.rt[IDX_W-1:0]];
      a_vld_r <= dq_data.rs_ok ? vld_r[dq_data.rs[IDX_W-1:0]] : 1'b0;
      b_vld_r <= dq_data.rt_ok ? vld_r[dq_data.rt[IDX_W-1:0]] : 1'b0;
    end
    if (ex_fire && ex_r.wr_en) begin
      rf_mem[ex_r.wr_idx[IDX_W-1:0]] <= wval;
    end
  end

  // Operands: forward the write made as this beat was read
  assign opa     = (lw_en_r && lw_idx_r == ex_r.rs) ? lw_val_r :
                   (a_vld_r ? rda_r : 32'd0);
  assign opb_reg = (lw_en_r && lw_idx_r == ex_r.rt) ? lw_val_r :
                   (b_vld_r ? rdb_r : 32'd0);
  assign opb     = ex_r.use_imm ? ex_r.imm : opb_reg;
  assign pc_step = pc_r + PC_STEP;

  // ALU
  always_comb begin
    case (ex_r.alu_op)
      ALU_ADD: alu = opa + opb;
      ALU_SUB: alu = opa - opb;
      ALU_AND: alu = opa & opb;
      ALU_OR:  alu = opa | opb;
      default: alu = opa + opb;
    endcase
  end

  assign wval = ex_r.link ? pc_step : alu;

  // Next PC
  always_comb begin
    case (ex_r.pc_sel)
      PCS_HOLD:   next_pc = pc_r;
      PCS_STEP:   next_pc = pc_step;
      PCS_TARGET: next_pc = ex_r.target;
      PCS_RS:     next_pc = opa;
      default:    next_pc = pc_r;
    endcase
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (ex_fire) begin
      out_r.next_pc     <= next_pc;
      out_r.write_valid <= ex_r.wr_en;
      out_r.write_index <= ex_r.wr_en ? ex_r.wr_idx : 5'd0;
      out_r.write_value <= ex_r.wr_en ? wval : 32'd0;
      lw_idx_r          <= ex_r.wr_idx;
      lw_val_r          <= wval;
    end
  end

  // Control state: stage valids, PC, entry valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ex_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      lw_en_r     <= 1'b0;
      pc_r        <= '0;
      vld_r       <= '0;
    end else begin
      if (pop) begin
        ex_valid_r <= 1'b1;
      end else if (ex_fire) begin
        ex_valid_r <= 1'b0;
      end
      if (ex_fire) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (ex_fire) begin
        lw_en_r <= ex_r.wr_en;
        pc_r    <= next_pc;
        if (ex_r.wr_en) begin
          vld_r[ex_r.wr_idx[IDX_W-1:0]] <= 1'b1;
        end
      end
    end
  end

endmodule

>>> design/risc_subset_execute_unit_top.sv
// Path: a result is valid once its input beat has passed the queue write at acceptance,
// then the register file read, then execute; it is held back while the result side stalls.
// Throughput: one instruction per cycle while the result side does not stall.
// Reset (rst_n, synchronous): clears PC, queue and stage valids, and the per-register
// valid bits so every register reads as zero until written.
// Depends on rsx_pkg, rsx_front, rsx_queue and rsx_back.
module risc_subset_execute_unit_top import rsx_pkg::*; #(
  parameter int NUM_REGS = NUM_REGS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  output logic in_ready,
  input  in_t  in_data,
  output logic out_valid,
  input  logic out_ready,
  output out_t out_data
);

  dec_t dec, dq_data;
  logic dq_valid, dq_ready;

  // Classify the incoming beat
  rsx_front #(.NUM_REGS(NUM_REGS)) u_front (
    .in_data (in_data),
    .dec     (dec)
  );

  // Buffer classified beats
  rsx_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_data  (dec),
    .pop_valid  (dq_valid),
    .pop_ready  (dq_ready),
    .pop_data   (dq_data)
  );

  // Execute and report
  rsx_back #(.NUM_REGS(NUM_REGS)) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .dq_valid  (dq_valid),
    .dq_ready  (dq_ready),
    .dq_data   (dq_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_full_not_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> dq_valid)
    else $error("queue full while empty");

  a_nowrite_clean: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_data.write_valid) |->
      (out_data.write_index == 5'd0 && out_data.write_value == 32'sd0))
    else $error("result without write carries index or value");

  a_write_index_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.write_valid) |->
      (out_data.write_index != 5'd0 && int'(out_data.write_index) < NUM_REGS))
    else $error("write reported to register zero or beyond the file");
`endif

endmodule
